// File: hdl/assert_macros.svh
// assertion macros shared by the depth back-projection rtl
// expects clk and rst_n in the scope of every use; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// expression holds on every edge out of reset
`define DPW_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dpw check failed");
// consequent holds on the same edge as the antecedent
`define DPW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpw check failed");
// consequent holds on the edge after the antecedent
`define DPW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpw check failed");
`else
`define DPW_ASSERT(label, expr)
`define DPW_ASSERT_IMPL(label, ante, cons)
`define DPW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/dpw_pkg.sv
// shared widths, constants and types for the depth back-projection pipeline
// no dependencies
package dpw_pkg;

    // pixel coordinate bits actually used
    localparam int COORD_BITS = 12;

    // fixed field widths
    localparam int PIXEL_W    = 12;
    localparam int DEPTH_W    = 24;
    localparam int MAXD_W     = 23;
    localparam int SHIFT_W    = 32;
    localparam int QUAT_W     = 16;
    localparam int WORLD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // register map of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DEPTH = 3'd0,
        REG_SHIFT_X   = 3'd1,
        REG_SHIFT_Y   = 3'd2,
        REG_SHIFT_Z   = 3'd3,
        REG_QUAT_W    = 3'd4,
        REG_QUAT_X    = 3'd5,
        REG_QUAT_Y    = 3'd6,
        REG_QUAT_Z    = 3'd7
    } cfg_reg_t;

    // pinhole model
    localparam int CENTER_COL = 320;
    localparam int CENTER_ROW = 240;
    localparam int CENTER_W   = 9;
    localparam int FOCAL_PIX  = 554;
    localparam int FOCAL_BITS = 10;
    localparam int FOCAL_HALF = FOCAL_PIX / 2;

    // back-projection datapath widths
    localparam int COL_W     = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam int DIFF_W    = ((COL_W > CENTER_W) ? COL_W : CENTER_W) + 1;
    localparam int PROD_W    = DEPTH_W + DIFF_W;
    localparam int MAG_W     = DEPTH_W - 2 + DIFF_W;
    localparam int DIV_SHIFT = MAG_W + 1;
    localparam int RECIP_W   = DIV_SHIFT - (FOCAL_BITS - 1);
    localparam int LO_W      = (MAG_W + 1) / 2;
    localparam int HI_W      = MAG_W - LO_W;
    localparam int PSUM_W    = MAG_W + RECIP_W + 1;
    localparam int QUO_W     = MAG_W - (FOCAL_BITS - 1);
    localparam int CAM_W     = QUO_W + 1;

    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'((64'd1 << DIV_SHIFT) / FOCAL_PIX);

    // rotation datapath widths
    localparam int PRD_W    = 2 * QUAT_W;
    localparam int ROT_W    = 2 * QUAT_W + 2;
    localparam int PP_W     = ROT_W + CAM_W;
    localparam int ACC_W    = PP_W + 2;
    localparam int ROT_FRAC = 28;
    localparam int RND_W    = ACC_W - ROT_FRAC;
    localparam int SUM_W    = RND_W + 2;

    // divider pipeline depth
    localparam int DIV_STAGES = 6;

    typedef struct packed {
        logic [DIV_STAGES-1:0] en;   // stage load enables
        logic [DIV_STAGES-1:0] vld;  // stage holds a live request
    } dpw_div_ctl_t;

endpackage

// File: hdl/depth_pixel_to_world_point.sv
// top level: depth pixel back-projection through a fixed pinhole and a configured pose
// depends on dpw_pkg, dpw_focal_div and assert_macros.svh
`include "assert_macros.svh"

// Takes one depth request per cycle while in_ready is high (pixel column, row and Q.16
// depth) and returns the world point in Q.16 meters. A request whose depth is not in
// (0, max_depth) yields no result and simply drops out of the pipeline. Throughput is
// one request per clock while out_ready is high; the result passes 11 register stages,
// the first loaded at the accepting edge: range check and depth times pixel offset, a
// six-stage divide by the focal length (reciprocal multiply in two halves, then one
// correction), the nine rotation products, the three dot-product sums, rounding, and
// translation add with saturation into the output register. Each stage carries its own
// valid bit and loads whenever it is empty or its contents move on, so bubbles close up
// and input is still taken while a result waits in the output register. The rotation
// matrix is rebuilt from the quaternion registers, through the product registers and
// then the matrix registers after every write, before a new request can reach it.
module depth_pixel_to_world_point (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_write,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]         cfg_data,
    // pixel requests
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [dpw_pkg::PIXEL_W-1:0]            pixel_column,
    input  logic [dpw_pkg::PIXEL_W-1:0]            pixel_row,
    input  logic signed [dpw_pkg::DEPTH_W-1:0]     depth_value,
    // world points
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [dpw_pkg::WORLD_W-1:0]     world_x,
    output logic signed [dpw_pkg::WORLD_W-1:0]     world_y,
    output logic signed [dpw_pkg::WORLD_W-1:0]     world_z
);
    import dpw_pkg::*;

    localparam int NSTG     = DIV_STAGES + 5;
    localparam int DEP_LAST = DIV_STAGES;   // depth copy that lines up with the divider output
    localparam int ST_PROD  = DIV_STAGES + 1;
    localparam int ST_SUM   = DIV_STAGES + 2;
    localparam int ST_RND   = DIV_STAGES + 3;
    localparam int ST_OUT   = DIV_STAGES + 4;

    // configuration registers
    logic [MAXD_W-1:0]         max_depth_reg;
    logic signed [SHIFT_W-1:0] shift_reg [3];
    logic signed [QUAT_W-1:0]  qw_reg, qx_reg, qy_reg, qz_reg;

    // rotation matrix, built from the quaternion in two steps
    logic signed [PRD_W-1:0]   ww_reg, xx_reg, yy_reg, zz_reg, xy_reg;
    logic signed [PRD_W-1:0]   wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [ROT_W-1:0]   rot_reg [3][3];

    // pipeline control
    logic [NSTG-1:0]           v_reg;
    logic [NSTG:0]             adv;
    logic                      keep;
    dpw_div_ctl_t              div_ctl;

    // first stage
    logic [COL_W-1:0]          col_used, row_used;
    logic signed [DIFF_W-1:0]  dcol, drow;
    logic signed [PROD_W-1:0]  pcx_reg, pcy_reg;
    logic signed [DEPTH_W-1:0] dep_reg [DEP_LAST+1];

    // camera point from the dividers
    logic signed [CAM_W-1:0]   cam_x, cam_y;
    logic signed [CAM_W-1:0]   cam [3];

    // rotation and output stages
    logic signed [PP_W-1:0]    pp_reg [3][3];
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic                      rneg_reg [3];
    logic [ACC_W-1:0]          rmag_reg [3];
    logic signed [SUM_W-1:0]   wsum [3];
    logic signed [WORLD_W-1:0] wout_next [3];
    logic signed [WORLD_W-1:0] wout_reg [3];

    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (ROT_FRAC - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(WORLD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // ---------------------------------------------------------------
    // configuration port; the user must write it only while the pipeline is empty (the block does not check this)
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= MAXD_W'(655360);
            shift_reg[0]  <= '0;
            shift_reg[1]  <= '0;
            shift_reg[2]  <= '0;
            qw_reg        <= QUAT_W'(16384);
            qx_reg        <= '0;
            qy_reg        <= '0;
            qz_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_DEPTH: max_depth_reg <= cfg_data[MAXD_W-1:0];
                REG_SHIFT_X:   shift_reg[0]  <= $signed(cfg_data[SHIFT_W-1:0]);
                REG_SHIFT_Y:   shift_reg[1]  <= $signed(cfg_data[SHIFT_W-1:0]);
                REG_SHIFT_Z:   shift_reg[2]  <= $signed(cfg_data[SHIFT_W-1:0]);
                REG_QUAT_W:    qw_reg        <= $signed(cfg_data[QUAT_W-1:0]);
                REG_QUAT_X:    qx_reg        <= $signed(cfg_data[QUAT_W-1:0]);
                REG_QUAT_Y:    qy_reg        <= $signed(cfg_data[QUAT_W-1:0]);
                REG_QUAT_Z:    qz_reg        <= $signed(cfg_data[QUAT_W-1:0]);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // rotation matrix in q28: quaternion products, then the standard form
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        ww_reg <= qw_reg * qw_reg;
        xx_reg <= qx_reg * qx_reg;
        yy_reg <= qy_reg * qy_reg;
        zz_reg <= qz_reg * qz_reg;
        xy_reg <= qx_reg * qy_reg;
        wz_reg <= qw_reg * qz_reg;
        xz_reg <= qx_reg * qz_reg;
        wy_reg <= qw_reg * qy_reg;
        yz_reg <= qy_reg * qz_reg;
        wx_reg <= qw_reg * qx_reg;

        rot_reg[0][0] <= ROT_W'(ww_reg) + ROT_W'(xx_reg) - ROT_W'(yy_reg) - ROT_W'(zz_reg);
        rot_reg[0][1] <= (ROT_W'(xy_reg) - ROT_W'(wz_reg)) <<< 1;
        rot_reg[0][2] <= (ROT_W'(xz_reg) + ROT_W'(wy_reg)) <<< 1;
        rot_reg[1][0] <= (ROT_W'(xy_reg) + ROT_W'(wz_reg)) <<< 1;
        rot_reg[1][1] <= ROT_W'(ww_reg) - ROT_W'(xx_reg) + ROT_W'(yy_reg) - ROT_W'(zz_reg);
        rot_reg[1][2] <= (ROT_W'(yz_reg) - ROT_W'(wx_reg)) <<< 1;
        rot_reg[2][0] <= (ROT_W'(xz_reg) - ROT_W'(wy_reg)) <<< 1;
        rot_reg[2][1] <= (ROT_W'(yz_reg) + ROT_W'(wx_reg)) <<< 1;
        rot_reg[2][2] <= ROT_W'(ww_reg) - ROT_W'(xx_reg) - ROT_W'(yy_reg) + ROT_W'(zz_reg);
    end

    // ---------------------------------------------------------------
    // stage advance: a stage loads when empty or when its request moves on
    // ---------------------------------------------------------------
    always_comb
    begin
        adv[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--)
            adv[k] = !v_reg[k] || adv[k+1];
    end

    assign in_ready = adv[0];

    // depth range check; a rejected request never gets a valid bit
    assign keep = in_valid && (depth_value > 0) &&
                  (MAXD_W'(depth_value[DEPTH_W-2:0]) < max_depth_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= keep;
            for (int k = 1; k < NSTG; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // stage 1: pixel offsets from the principal point, times depth
    // ---------------------------------------------------------------
    assign col_used = pixel_column[COL_W-1:0];
    assign row_used = pixel_row[COL_W-1:0];
    assign dcol     = $signed(DIFF_W'(col_used)) - $signed(DIFF_W'(CENTER_COL));
    assign drow     = $signed(DIFF_W'(row_used)) - $signed(DIFF_W'(CENTER_ROW));

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pcx_reg    <= PROD_W'(depth_value) * PROD_W'(dcol);
            pcy_reg    <= PROD_W'(depth_value) * PROD_W'(drow);
            dep_reg[0] <= depth_value;
        end
        // depth rides alongside the dividers as the camera z
        for (int k = 1; k <= DEP_LAST; k++)
            if (adv[k])
                dep_reg[k] <= dep_reg[k-1];
    end

    // ---------------------------------------------------------------
    // stages 2 to 7: divide by the focal length
    // ---------------------------------------------------------------
    assign div_ctl.en  = adv[DIV_STAGES:1];
    assign div_ctl.vld = v_reg[DIV_STAGES:1];

    dpw_focal_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .prod  (pcx_reg),
        .quo   (cam_x)
    );

    dpw_focal_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .prod  (pcy_reg),
        .quo   (cam_y)
    );

    assign cam[0] = cam_x;
    assign cam[1] = cam_y;
    assign cam[2] = CAM_W'(dep_reg[DEP_LAST]);

    // ---------------------------------------------------------------
    // stages 8 to 11: rotate, round, translate, saturate
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rneg_reg[i])
                wsum[i] = SUM_W'(shift_reg[i]) - $signed(SUM_W'(rmag_reg[i][ACC_W-1:ROT_FRAC]));
            else
                wsum[i] = SUM_W'(shift_reg[i]) + $signed(SUM_W'(rmag_reg[i][ACC_W-1:ROT_FRAC]));
            if (wsum[i] > SAT_MAX)
                wout_next[i] = WORLD_W'(SAT_MAX);
            else if (wsum[i] < SAT_MIN)
                wout_next[i] = WORLD_W'(SAT_MIN);
            else
                wout_next[i] = WORLD_W'(wsum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (adv[ST_PROD])
                for (int j = 0; j < 3; j++)
                    pp_reg[i][j] <= PP_W'(rot_reg[i][j]) * PP_W'(cam[j]);
            if (adv[ST_SUM])
                acc_reg[i] <= ACC_W'(pp_reg[i][0]) + ACC_W'(pp_reg[i][1]) + ACC_W'(pp_reg[i][2]);
            // magnitude plus half an lsb, ties go away from zero
            if (adv[ST_RND])
            begin
                rneg_reg[i] <= acc_reg[i][ACC_W-1];
                if (acc_reg[i][ACC_W-1])
                    rmag_reg[i] <= ~acc_reg[i] + RND_HALF + ACC_W'(1);
                else
                    rmag_reg[i] <= acc_reg[i] + RND_HALF;
            end
            if (adv[ST_OUT])
                wout_reg[i] <= wout_next[i];
        end
    end

    assign out_valid = v_reg[ST_OUT];
    assign world_x   = wout_reg[0];
    assign world_y   = wout_reg[1];
    assign world_z   = wout_reg[2];

    `DPW_ASSERT_NEXT(a_reject_drops, in_valid && in_ready && (depth_value <= 0), !v_reg[0])
    `DPW_ASSERT_IMPL(a_empty_out_takes, !v_reg[ST_OUT], in_ready)
    `DPW_ASSERT_IMPL(a_full_stall, (&v_reg) && !out_ready, !in_ready)
    `DPW_ASSERT_IMPL(a_out_source, $rose(out_valid), $past(v_reg[ST_RND]))

endmodule

// File: hdl/dpw_focal_div.sv
// pipelined signed divide by the focal length, rounded to nearest, ties away from zero
// depends on dpw_pkg and assert_macros.svh
`include "assert_macros.svh"

module dpw_focal_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dpw_pkg::dpw_div_ctl_t               ctl,
    input  logic signed [dpw_pkg::PROD_W-1:0]   prod,
    output logic signed [dpw_pkg::CAM_W-1:0]    quo
);
    import dpw_pkg::*;

    logic                    neg_next;
    logic [MAG_W-1:0]        mag_next;
    logic [PSUM_W-1:0]       psum;
    logic [MAG_W-1:0]        rem;

    logic                    neg0_reg, neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [MAG_W-1:0]        mag0_reg, mag1_reg, mag2_reg, mag3_reg;
    logic [HI_W+RECIP_W-1:0] ph_reg;
    logic [LO_W+RECIP_W-1:0] pl_reg;
    logic [QUO_W-1:0]        q0_reg, q3_reg, q4_reg;
    logic [MAG_W-1:0]        qp_reg;
    logic signed [CAM_W-1:0] quo_reg;

    // magnitude plus half the divisor in one adder
    always_comb
    begin
        neg_next = prod[PROD_W-1];
        if (neg_next)
            mag_next = MAG_W'(~prod) + MAG_W'(FOCAL_HALF + 1);
        else
            mag_next = MAG_W'(prod) + MAG_W'(FOCAL_HALF);
    end

    assign psum = (PSUM_W'(ph_reg) << LO_W) + PSUM_W'(pl_reg);
    assign rem  = mag3_reg - qp_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            neg0_reg <= neg_next;
            mag0_reg <= mag_next;
        end
        // reciprocal product, split in two halves
        if (ctl.en[1])
        begin
            neg1_reg <= neg0_reg;
            mag1_reg <= mag0_reg;
            ph_reg   <= (HI_W+RECIP_W)'(mag0_reg[MAG_W-1:LO_W]) * (HI_W+RECIP_W)'(DIV_RECIP);
            pl_reg   <= (LO_W+RECIP_W)'(mag0_reg[LO_W-1:0]) * (LO_W+RECIP_W)'(DIV_RECIP);
        end
        // estimate, low by at most one
        if (ctl.en[2])
        begin
            neg2_reg <= neg1_reg;
            mag2_reg <= mag1_reg;
            q0_reg   <= QUO_W'(psum >> DIV_SHIFT);
        end
        if (ctl.en[3])
        begin
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            q3_reg   <= q0_reg;
            qp_reg   <= MAG_W'(q0_reg) * MAG_W'(FOCAL_PIX);
        end
        // one correction step
        if (ctl.en[4])
        begin
            neg4_reg <= neg3_reg;
            q4_reg   <= (rem >= MAG_W'(FOCAL_PIX)) ? q3_reg + QUO_W'(1) : q3_reg;
        end
        if (ctl.en[5])
        begin
            if (neg4_reg)
                quo_reg <= -$signed({1'b0, q4_reg});
            else
                quo_reg <= $signed({1'b0, q4_reg});
        end
    end

    assign quo = quo_reg;

    `DPW_ASSERT_IMPL(a_rem_bound, ctl.vld[3], rem < MAG_W'(2 * FOCAL_PIX))
    `DPW_ASSERT_IMPL(a_vld_needs_room, ctl.vld[5] && ctl.en[5], ctl.en[4])
    `DPW_ASSERT_IMPL(a_en_chain, !ctl.vld[0], ctl.en[0])

endmodule
